### rtl/npc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package npc_pkg;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_ZERO  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_DROP  = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [9:0] DIST_MAX = 10'd765;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  index;
        logic [23:0] data;
    } npc_op_t;

endpackage
`default_nettype wire

### rtl/npc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/npc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module npc_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_kind,
    input  wire logic [31:0]     s_pixel_word,
    input  wire logic [7:0]      s_entry_index,
    input  wire logic [23:0]     s_entry_color,
    output npc_pkg::npc_op_t     q_head,
    output logic                 q_empty,
    input  wire logic            q_pop
);
    import npc_pkg::*;

    npc_op_t            op_in;
    npc_op_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               push;

    // Classify the incoming transfer
    always_comb begin
        op_in.index = s_entry_index;
        if (s_kind) begin
            op_in.op   = ({1'b0, s_entry_index} < 9'(PALETTE_DEPTH)) ? OP_WRITE : OP_DROP;
            op_in.data = s_entry_color;
        end else begin
            op_in.op   = (s_pixel_word == 32'd0) ? OP_ZERO : OP_MAP;
            op_in.data = s_pixel_word[23:0];
        end
    end

    assign s_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && (op_in.op != OP_DROP);
    assign q_empty = (count_reg == '0);
    assign q_head  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !q_pop |=> count_reg <= (QPTR_W+1)'(QUEUE_DEPTH) && !q_empty)
        else $error("queue count out of range");

endmodule
`default_nettype wire

### rtl/npc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module npc_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [7:0]      colors_in_use,
    input  npc_pkg::npc_op_t     q_head,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_color_index
);
    import npc_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    function automatic logic [9:0] manhattan(input logic [23:0] p, input logic [23:0] q);
        logic [7:0] dr, dg, db;
        dr = (p[23:16] >= q[23:16]) ? p[23:16] - q[23:16] : q[23:16] - p[23:16];
        dg = (p[15:8]  >= q[15:8])  ? p[15:8]  - q[15:8]  : q[15:8]  - p[15:8];
        db = (p[7:0]   >= q[7:0])   ? p[7:0]   - q[7:0]   : q[7:0]   - p[7:0];
        return 10'(dr) + 10'(dg) + 10'(db);
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] last_reg, last_next;
    logic [23:0]   pixel_reg, pixel_next;
    logic [7:0]    best_reg, best_next;
    logic [9:0]    best_dist_reg, best_dist_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_index_reg, m_index_next;

    logic          ram_we;
    logic          ram_re;
    logic [23:0]   ram_rdata;
    logic [9:0]    cand_dist;
    logic [8:0]    limit;
    logic          few_colors;
    logic          out_free;

    npc_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_head.index[AW-1:0]),
        .wdata (q_head.data),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign ram_re     = (state_reg == ST_SCAN);
    assign cand_dist  = manhattan(pixel_reg, ram_rdata);
    assign limit      = (9'(colors_in_use) > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH)
                                                                 : 9'(colors_in_use);
    assign few_colors = (limit <= 9'd2);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        pixel_next     = pixel_reg;
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        m_valid_next   = m_valid_reg;
        m_index_next   = m_index_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Keep the earlier entry on a tie
        if (rd_valid_reg && (cand_dist < best_dist_reg)) begin
            best_dist_next = cand_dist;
            best_next      = 8'(rd_idx_reg);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    unique case (q_head.op)
                        OP_WRITE: begin
                            q_pop  = 1'b1;
                            ram_we = 1'b1;
                        end
                        OP_ZERO: begin
                            if (out_free) begin
                                q_pop        = 1'b1;
                                m_valid_next = 1'b1;
                                m_index_next = 8'd0;
                            end
                        end
                        OP_MAP: begin
                            if (few_colors) begin
                                if (out_free) begin
                                    q_pop        = 1'b1;
                                    m_valid_next = 1'b1;
                                    m_index_next = 8'd1;
                                end
                            end else begin
                                q_pop          = 1'b1;
                                pixel_next     = q_head.data;
                                addr_next      = AW'(1);
                                last_next      = AW'(limit - 9'd1);
                                best_next      = 8'd1;
                                best_dist_next = '1;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_valid_next = 1'b1;
                rd_idx_next   = addr_reg;
                addr_next     = addr_reg + AW'(1);
                if (addr_reg == last_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // Wait for the last compare to settle
                if (!rd_valid_reg && out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = best_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        last_reg      <= last_next;
        pixel_reg     <= pixel_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
        rd_idx_reg    <= rd_idx_next;
        m_index_reg   <= m_index_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_color_index = m_index_reg;

    a_read_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> state_reg != ST_IDLE)
        else $error("palette read data arrived outside a scan");

    a_scan_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |=> rd_valid_reg)
        else $error("scan cycle issued no read");

    a_best_found: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN && !rd_valid_reg |-> best_dist_reg <= DIST_MAX)
        else $error("scan ended without a compared entry");

endmodule
`default_nettype wire

### rtl/nearest_palette_color_mapper.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_kind, s_pixel_word, s_entry_index, s_entry_color
// m_        out        m_valid / m_ready    m_color_index
// cfg_      in         cfg_valid / cfg_ready cfg_data (colors_in_use)
//
// The front takes one transfer per cycle, while the queue is not full, into a four-entry queue.
// A palette write or a zero pixel is handled straight from the queue head in the back;
// a searched pixel scans entries 1 to min(colors_in_use, PALETTE_DEPTH) - 1, one entry
// per cycle through the palette RAM read port, then drains the last compare to finish.
// Reset (aresetn low, synchronous) empties the queue and the result register;
// palette contents are kept. A stalled m_ready holds the result and backs up the queue.
module nearest_palette_color_mapper #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [31:0] s_pixel_word,
    input  wire logic [7:0]  s_entry_index,
    input  wire logic [23:0] s_entry_color,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_color_index,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);
    import npc_pkg::*;

    logic [7:0] colors_in_use_reg;
    npc_op_t    q_head;
    logic       q_empty;
    logic       q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colors_in_use_reg <= 8'd2;
        end else if (cfg_valid && cfg_ready) begin
            colors_in_use_reg <= cfg_data;
        end
    end

    npc_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pixel_word  (s_pixel_word),
        .s_entry_index (s_entry_index),
        .s_entry_color (s_entry_color),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop)
    );

    npc_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .colors_in_use (colors_in_use_reg),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_color_index (m_color_index)
    );

endmodule
`default_nettype wire

### tb/tb_nearest_palette_color_mapper.sv
`timescale 1ns / 1ps

module tb_nearest_palette_color_mapper;

    localparam int PAL_DEPTH = 256;
    localparam logic KIND_MAP = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam int IDLE_SETTLE = 300;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic        kind;
        logic [31:0] pixel;
        logic [7:0]  index;
        logic [23:0] color;
    } pal_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [31:0] s_pixel_word = '0;
    logic [7:0]  s_entry_index = '0;
    logic [23:0] s_entry_color = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_color_index;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // predictor state, updated in transfer order
    logic [23:0] palette [PAL_DEPTH];
    logic [7:0]  pal_colors = 8'd2;

    pal_item_t   pending_items[$];
    logic [7:0]  expected_indices[$];
    pal_item_t   cur_item;

    // stimulus-side bookkeeping: entries that are safe to search
    bit          entry_loaded [PAL_DEPTH];
    logic [23:0] tie_pool [4];

    int maps_sent = 0;
    int writes_sent = 0;
    int indices_checked = 0;
    int err_count = 0;
    int settings_used = 0;
    int tx_gap = 0;
    int tx_count = 0;
    bit tx_calm = 1'b0;
    int rx_wait = 0;
    int rx_count = 0;
    bit rx_calm = 1'b0;
    bit hold_off = 1'b0;

    int phase_colors [12] = '{4, 0, 1, 255, 3, -1, -1, -1, -1, -1, 2, 255};
    int phase_items  [12] = '{150, 40, 40, 120, 80, 100, 100, 100, 100, 100, 60, 20};

    nearest_palette_color_mapper #(
        .PALETTE_DEPTH(PAL_DEPTH)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_pixel_word (s_pixel_word),
        .s_entry_index(s_entry_index),
        .s_entry_color(s_entry_color),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_color_index(m_color_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int chan_gap(logic [7:0] a, logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic int color_dist(logic [23:0] p, logic [23:0] q);
        return chan_gap(p[23:16], q[23:16]) + chan_gap(p[15:8], q[15:8])
             + chan_gap(p[7:0], q[7:0]);
    endfunction

    // lowest index with the least distance; entry 0 is never searched
    function automatic logic [7:0] nearest_entry(logic [31:0] px);
        int limit;
        int best;
        int best_d;
        int d;
        int i;
        if (px == 32'd0) return 8'd0;
        limit = (pal_colors > PAL_DEPTH) ? PAL_DEPTH : int'(pal_colors);
        best = 1;
        if (limit > 2) begin
            best_d = color_dist(px[23:0], palette[1]);
            for (i = 2; i < limit; i++) begin
                d = color_dist(px[23:0], palette[i]);
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
        end
        return best[7:0];
    endfunction

    function automatic void accept_item(pal_item_t it);
        if (it.kind == KIND_WRITE) begin
            if (it.index < PAL_DEPTH) palette[it.index] = it.color;
            writes_sent++;
        end else begin
            expected_indices.push_back(nearest_entry(it.pixel));
            maps_sent++;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 30) $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_color();
        if ($urandom_range(0, 1) == 0) return tie_pool[$urandom_range(0, 3)];
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 15))
            0: return 32'd0;
            1: return {8'($urandom_range(1, 255)), 24'd0};
            2, 3: return {8'($urandom), tie_pool[$urandom_range(0, 3)]};
            default: return {8'($urandom), rand_chan(), rand_chan(), rand_chan()};
        endcase
    endfunction

    function automatic void push_write(logic [7:0] idx, logic [23:0] color);
        pal_item_t it;
        it.kind = KIND_WRITE;
        it.pixel = $urandom;
        it.index = idx;
        it.color = color;
        entry_loaded[idx] = 1'b1;
        pending_items.push_back(it);
    endfunction

    function automatic void push_map(logic [31:0] px);
        pal_item_t it;
        it.kind = KIND_MAP;
        it.pixel = px;
        it.index = 8'($urandom);
        it.color = 24'($urandom);
        pending_items.push_back(it);
    endfunction

    // drained means nothing queued, nothing offered and no index outstanding;
    // then let trailing palette writes retire
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_indices.size() != 0);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic set_colors(input logic [7:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pal_colors = v;
        settings_used++;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic [7:0] colors, input int n);
        int i;
        set_colors(colors);
        for (i = 0; i < 4; i++) tie_pool[i] = 24'($urandom);
        // load every entry the search will touch before the first pixel
        for (i = 1; i < colors; i++)
            if (!entry_loaded[i]) push_write(i[7:0], rand_color());
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 3) push_write(8'($urandom), rand_color());
            else push_map(rand_pixel());
        end
    endtask

    initial begin
        int p;
        int c;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // two colors in use after reset: nothing is searched
        push_map(32'h0000_0000);
        push_map(32'hFF00_0000);
        push_map(32'hFFFF_FFFF);
        push_map(32'h0000_0001);
        push_write(8'd1, 24'h000000);
        push_write(8'd2, 24'hFFFFFF);
        push_write(8'd3, 24'h808080);
        push_write(8'd4, 24'h808080);
        push_write(8'd0, 24'h123456);
        push_write(8'd255, 24'hFFFFFF);
        push_write(8'd5, 24'h7F8081);

        // five colors: exact hits, ties between duplicates and across entries
        set_colors(8'd5);
        push_map(32'h00FF_FFFF);
        push_map(32'h0000_0000);
        push_map(32'hFF00_0000);
        push_map(32'h0080_8080);
        push_map(32'h0040_4040);
        push_map(32'h00C0_C0C0);
        push_map(32'h0012_3456);

        for (p = 0; p < 12; p++) begin
            c = (phase_colors[p] < 0) ? $urandom_range(2, 40) : phase_colors[p];
            run_phase(c[7:0], phase_items[p]);
        end

        wait_drained();
        $display("Mapped %0d pixels and wrote %0d palette entries over %0d color counts,",
                 maps_sent, writes_sent, settings_used);
        $display("from 0 up to 255, with random gaps on both sides and one long output hold.");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // sender: one item per transfer, random gap drawn for each item outside calm spells
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) accept_item(cur_item);
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_kind <= cur_item.kind;
                    s_pixel_word <= cur_item.pixel;
                    s_entry_index <= cur_item.index;
                    s_entry_color <= cur_item.color;
                    s_valid <= 1'b1;
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 5);
                    tx_count++;
                    if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each index transfer against the oldest prediction
    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_indices.size() == 0) begin
                    report_mismatch($sformatf("color index %0d with no pixel pending",
                                              m_color_index));
                end else begin
                    want = expected_indices.pop_front();
                    if (m_color_index !== want)
                        report_mismatch($sformatf("color index %0d, predicted %0d",
                                                  m_color_index, want));
                end
                indices_checked++;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
                rx_count++;
                if (rx_count % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // hold off the output long enough for the input side to back up
    initial begin
        wait (indices_checked >= 40);
        @(negedge aclk) hold_off = 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        @(negedge aclk) hold_off = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("Timeout: %0d indices still outstanding, %0d items unsent",
                 expected_indices.size(), pending_items.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
